@@ hw/rtl/dbam_pkg.sv @@
// dbam_pkg: shared widths, codes, constants and the controller command struct
// for the block availability map. No dependencies.
package dbam_pkg;

	localparam int MODE_W     = 2;
	localparam int TRACK_W    = 8;
	localparam int SECTOR_W   = 8;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 8;
	localparam int TOTAL_W    = 15;
	localparam int TC_W       = 8;
	localparam int SPT_W      = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;
	localparam int WALK_W     = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_QUERY  = 2'd0,
		MODE_ALLOC  = 2'd1,
		MODE_FREE   = 2'd2,
		MODE_FORMAT = 2'd3
	} mode_t;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_TRACK = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SEC   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECTORS     = 4'd1;

	localparam logic [TC_W-1:0]    TC_RESET       = 8'd80;
	localparam logic [SPT_W-1:0]   SPT_RESET      = 5'd20;
	localparam logic [SPT_W-1:0]   WIDE_SPT_MIN   = 5'd16;
	localparam logic [23:0]        WIDE_PATTERN   = 24'h0FFFFF;
	localparam logic [23:0]        NARROW_PATTERN = 24'h03FFFF;
	localparam logic [23:0]        RESERVED_BITS  = 24'h000003;
	localparam logic [SPT_W-1:0]   RESERVED_CNT   = 5'd2;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'hFF;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX      = 15'h7FFF;

	typedef enum logic [1:0] {
		RD_IN   = 2'd0,
		RD_HELD = 2'd1,
		RD_WALK = 2'd2
	} rd_src_t;

	typedef struct packed {
		logic              ld_item;
		logic              rd_en;
		rd_src_t           rd_src;
		logic              sum_clr;
		logic              sum_rd;
		logic              exec;
		logic              fmt_wr;
		logic              fmt_done;
		logic [WALK_W-1:0] walk_idx;
	} dbam_cmd_t;

endpackage

@@ hw/rtl/dbam_if.sv @@
// dbam_if: valid/ready channel interfaces for items, results and register writes.
// Depends on dbam_pkg.
interface dbam_item_if import dbam_pkg::*;;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [TRACK_W-1:0]  track;
	logic [SECTOR_W-1:0] sector;
	modport source (output valid, mode, track, sector, input ready);
	modport sink (input valid, mode, track, sector, output ready);
endinterface

interface dbam_result_if import dbam_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                was_free;
	logic [COUNT_W-1:0]  track_free_count;
	logic [TOTAL_W-1:0]  total_free;
	modport source (output valid, status, was_free, track_free_count, total_free,
		input ready);
	modport sink (input valid, status, was_free, track_free_count, total_free,
		output ready);
endinterface

interface dbam_cfg_if import dbam_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/dbam_dp.sv @@
// dbam_dp: map/count memory with valid bits, config registers, read-modify-write
// logic, format pattern, free total and result registers. Depends on dbam_pkg.
module dbam_dp import dbam_pkg::*; #(
	parameter int MAX_TRACKS = 128,
	parameter int MAP_BITS   = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dbam_cmd_t             cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [MODE_W-1:0]     in_mode,
	input  logic [TRACK_W-1:0]    in_track,
	input  logic [SECTOR_W-1:0]   in_sector,
	output logic [STATUS_W-1:0]   status,
	output logic                  was_free,
	output logic [COUNT_W-1:0]    track_free_count,
	output logic [TOTAL_W-1:0]    total_free
);

	localparam int IW  = $clog2(MAX_TRACKS);
	localparam int SBW = $clog2(MAP_BITS);
	localparam int EW  = MAP_BITS + COUNT_W;
	localparam int SW  = $clog2(MAX_TRACKS * 255 + 1);
	localparam int NW  = TRACK_W + 1;
	localparam logic [NW-1:0] MAX_N = NW'(MAX_TRACKS);

	logic [TC_W-1:0]     tc_q;
	logic [SPT_W-1:0]    spt_q;
	mode_t               mode_q;
	logic [TRACK_W-1:0]  trk_q;
	logic [SECTOR_W-1:0] sec_q;

	logic [EW-1:0]         mem [MAX_TRACKS];
	logic [MAX_TRACKS-1:0] vld_q;
	logic [EW-1:0]         rd_s1;
	logic                  rd_vld_s1;
	logic                  sum_pend_s1;
	logic [SW-1:0]         total_q;
	logic [COUNT_W-1:0]    fmt_cnt_q;

	logic [NW-1:0]       n_use;
	logic                trk_ok, sec_ok, bit_free;
	logic [IW-1:0]       rd_addr, trk_idx, widx, wr_addr;
	logic [EW-1:0]       wr_data;
	logic                wr_en, ex_wr;
	logic [MAP_BITS-1:0] cur_map, new_map, pat, fmt_map;
	logic [COUNT_W-1:0]  cur_cnt, new_cnt, fmt_cnt;
	logic [SBW-1:0]      bidx;
	logic                tot_inc, tot_dec, in_use;
	logic [SW-1:0]       ex_total;

	function automatic logic [TOTAL_W-1:0] sat_total(input logic [SW-1:0] v);
		logic [16:0] w;
		w = 17'(v);
		return (w > 17'(TOTAL_MAX)) ? TOTAL_MAX : w[TOTAL_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q  <= TC_RESET;
			spt_q <= SPT_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == REG_TRACK_COUNT) tc_q <= cfg_data[TC_W-1:0];
			else if (cfg_idx == REG_SECTORS) spt_q <= cfg_data[SPT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			mode_q <= mode_t'(in_mode);
			trk_q  <= in_track;
			sec_q  <= in_sector;
		end
	end

	assign n_use   = ({1'b0, tc_q} > MAX_N) ? MAX_N : {1'b0, tc_q};
	assign trk_ok  = (trk_q != '0) && ({1'b0, trk_q} <= n_use);
	assign sec_ok  = (sec_q < SECTOR_W'(spt_q)) && (sec_q < SECTOR_W'(MAP_BITS));
	assign trk_idx = IW'(trk_q - TRACK_W'(1));
	assign widx    = cmd.walk_idx[IW-1:0];
	assign bidx    = sec_q[SBW-1:0];

	always_comb begin
		case (cmd.rd_src)
			RD_IN:   rd_addr = IW'(in_track - TRACK_W'(1));
			RD_HELD: rd_addr = trk_idx;
			RD_WALK: rd_addr = widx;
			default: rd_addr = trk_idx;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1     <= mem[rd_addr];
			rd_vld_s1 <= vld_q[rd_addr];
		end
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (wr_en) vld_q[wr_addr] <= 1'b1;
	end

	assign cur_map  = rd_vld_s1 ? rd_s1[EW-1:COUNT_W] : '0;
	assign cur_cnt  = rd_vld_s1 ? rd_s1[COUNT_W-1:0] : '0;
	assign bit_free = trk_ok && sec_ok && cur_map[bidx];

	always_comb begin
		new_map = cur_map;
		new_cnt = cur_cnt;
		tot_inc = 1'b0;
		tot_dec = 1'b0;
		if (trk_ok && sec_ok) begin
			case (mode_q)
				MODE_ALLOC: begin
					if (bit_free) begin
						new_map[bidx] = 1'b0;
						if (cur_cnt != '0) begin
							new_cnt = cur_cnt - COUNT_W'(1);
							tot_dec = 1'b1;
						end
					end
				end
				MODE_FREE: begin
					new_map[bidx] = 1'b1;
					if (cur_cnt != COUNT_MAX) begin
						new_cnt = cur_cnt + COUNT_W'(1);
						tot_inc = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign ex_wr = cmd.exec && trk_ok && sec_ok &&
		((mode_q == MODE_ALLOC) || (mode_q == MODE_FREE));
	assign ex_total = total_q + SW'(tot_inc) - SW'(tot_dec);

	// format: slot 0 is track 1 with its first two sectors taken
	assign pat    = (spt_q > WIDE_SPT_MIN) ? MAP_BITS'(WIDE_PATTERN) : MAP_BITS'(NARROW_PATTERN);
	assign in_use = NW'(widx) < n_use;

	always_comb begin
		fmt_map = '0;
		fmt_cnt = '0;
		if (in_use) begin
			if (widx == '0) begin
				fmt_map = pat & ~MAP_BITS'(RESERVED_BITS);
				fmt_cnt = (spt_q >= RESERVED_CNT) ? COUNT_W'(spt_q - RESERVED_CNT) : '0;
			end else begin
				fmt_map = pat;
				fmt_cnt = COUNT_W'(spt_q);
			end
		end
	end

	assign wr_en   = ex_wr || cmd.fmt_wr;
	assign wr_addr = cmd.fmt_wr ? widx : trk_idx;
	assign wr_data = cmd.fmt_wr ? {fmt_map, fmt_cnt} : {new_map, new_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			sum_pend_s1 <= 1'b0;
		end else begin
			sum_pend_s1 <= cmd.sum_rd && in_use;
			if (cmd.sum_clr) total_q <= '0;
			else if (sum_pend_s1) total_q <= total_q + SW'(cur_cnt);
			else if (cmd.fmt_wr) total_q <= ((widx == '0) ? '0 : total_q) + SW'(fmt_cnt);
			else if (cmd.exec) total_q <= ex_total;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fmt_wr && (widx == '0)) fmt_cnt_q <= fmt_cnt;
		if (cmd.exec) begin
			status           <= !trk_ok ? ST_BAD_TRACK : (!sec_ok ? ST_BAD_SEC : ST_OK);
			was_free         <= bit_free;
			track_free_count <= trk_ok ? new_cnt : '0;
			total_free       <= sat_total(ex_total);
		end else if (cmd.fmt_done) begin
			status           <= ST_OK;
			was_free         <= 1'b0;
			track_free_count <= fmt_cnt_q;
			total_free       <= sat_total(total_q);
		end
	end

endmodule

@@ hw/rtl/dbam_ctrl.sv @@
// dbam_ctrl: sequencer for item intake, total re-sum sweep, read-modify-write,
// format walk and result handoff. Depends on dbam_pkg.
module dbam_ctrl import dbam_pkg::*; #(
	parameter int MAX_TRACKS = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_format,
	input  logic      out_ready,
	input  logic      tc_wr,
	output logic      in_ready,
	output logic      out_valid,
	output dbam_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_SUM_END,
		S_EXEC,
		S_FMT,
		S_FMT_END
	} state_t;

	state_t            state_q;
	logic [WALK_W-1:0] walk_q;
	logic              dirty_q;
	logic              out_valid_q;
	logic              accept, out_free, last;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign last      = (walk_q == WALK_W'(MAX_TRACKS - 1));

	always_comb begin
		cmd          = '0;
		cmd.rd_src   = RD_IN;
		cmd.walk_idx = walk_q;
		case (state_q)
			S_IDLE: begin
				cmd.ld_item = accept;
				if (accept && !in_format) begin
					if (dirty_q) cmd.sum_clr = 1'b1;
					else cmd.rd_en = 1'b1;
				end
			end
			S_SUM: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_WALK;
				cmd.sum_rd = 1'b1;
			end
			S_SUM_END: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_HELD;
			end
			S_EXEC:    cmd.exec = out_free;
			S_FMT:     cmd.fmt_wr = 1'b1;
			S_FMT_END: cmd.fmt_done = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			walk_q      <= '0;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.exec || cmd.fmt_done || (out_valid_q && !out_ready);
			if (tc_wr) dirty_q <= 1'b1;
			else if (accept) dirty_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					walk_q <= '0;
					if (accept) begin
						if (in_format) state_q <= S_FMT;
						else if (dirty_q) state_q <= S_SUM;
						else state_q <= S_EXEC;
					end
				end
				S_SUM: begin
					walk_q <= walk_q + WALK_W'(1);
					if (last) state_q <= S_SUM_END;
				end
				S_SUM_END: state_q <= S_EXEC;
				S_EXEC: if (out_free) state_q <= S_IDLE;
				S_FMT: begin
					walk_q <= walk_q + WALK_W'(1);
					if (last) state_q <= S_FMT_END;
				end
				S_FMT_END: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/disk_block_availability_map_top.sv @@
// disk_block_availability_map_top: block availability map, controller plus datapath.
// Depends on dbam_pkg, dbam_if, dbam_ctrl, dbam_dp.
//
//  channel | dir | payload                                       | transfer when
//  item    | in  | mode, track, sector                           | valid && ready
//  result  | out | status, was_free, track_free_count, total_free | valid && ready
//  cfg     | in  | index, data (0 track_count, 1 sectors/track)  | valid && ready
//
// Query, allocate and free do one memory read, then one write-back with
// the result loaded into the output register.
// The first query, allocate or free after a track_count write first re-sums the free
// total by a sweep over the memory read port, then rereads the item's entry.
// Format: the accept cycle, one memory entry written per cycle, then the result load.
// Reset clears per-entry valid bits at once; no clearing pass. cfg is always ready.
// A held result stalls the write-back; the next item is not taken until then.
module disk_block_availability_map_top import dbam_pkg::*; #(
	parameter int MAX_TRACKS = 128,
	parameter int MAP_BITS   = 24
) (
	input logic         clk,
	input logic         arst_n,
	dbam_item_if.sink   item,
	dbam_result_if.source result,
	dbam_cfg_if.sink    cfg
);

	dbam_cmd_t cmd;
	logic      cfg_we;
	logic      tc_wr;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;
	assign tc_wr     = cfg_we && (cfg.index == REG_TRACK_COUNT);

	dbam_ctrl #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_format (item.mode == MODE_FORMAT),
		.out_ready (result.ready),
		.tc_wr     (tc_wr),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	dbam_dp #(
		.MAX_TRACKS(MAX_TRACKS),
		.MAP_BITS  (MAP_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg.index),
		.cfg_data         (cfg.data),
		.in_mode          (item.mode),
		.in_track         (item.track),
		.in_sector        (item.sector),
		.status           (result.status),
		.was_free         (result.was_free),
		.track_free_count (result.track_free_count),
		.total_free       (result.total_free)
	);

endmodule
